FILE: rtl/pali_pkg.sv
// ----------------------------------------------------------------------------
// pali_pkg: shared types and constants of the path arc length interpolator
// Request payloads, datapath commands and status, and the CORDIC angle table.
// ----------------------------------------------------------------------------
package pali_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_POINTS);

	// request function codes
	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// angles: Q2.13 radians, CORDIC angle in 2^-20 rad
	localparam logic signed [15:0] PI_Q13      = 16'sd25736;
	localparam logic signed [33:0] PI_W        = 34'sd25736;
	localparam logic signed [33:0] TWO_PI_W    = 34'sd51472;
	localparam logic [14:0]        HALF_PI_Q13 = 15'd12868;
	localparam logic [20:0]        HALF_PI_Z   = 21'd1647099;
	localparam int                 CORDIC_STEPS = 20;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [31:0]        query_distance;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic [31:0]        out_distance;
		logic signed [15:0] out_heading;
		logic [CNT_W-1:0]   point_count;
	} out_item_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_CLEAR,
		DP_FULL,
		DP_EMPTY,
		DP_DIFF,
		DP_SQX,
		DP_SQY,
		DP_SQRT,
		DP_NINIT,
		DP_NSTEP,
		DP_CORDIC,
		DP_HFIN,
		DP_WRPREV,
		DP_WRNEW,
		DP_EMIT_RD,
		DP_EMIT_P1,
		DP_EMIT_P2,
		DP_BSINIT,
		DP_BSUPD,
		DP_CAP1,
		DP_CAP2,
		DP_LDIFF,
		DP_LMUL,
		DP_DIV,
		DP_LFIN
	} dp_op_t;

	typedef enum logic [2:0] {
		RS_ZERO,
		RS_LAST,
		RS_MID,
		RS_LO,
		RS_HI
	} rsel_t;

	typedef enum logic [1:0] {
		LF_X,
		LF_Y,
		LF_H
	} lfield_t;

	typedef struct packed {
		dp_op_t     op;
		rsel_t      rsel;
		logic [4:0] idx;
		lfield_t    field;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       count_zero;
		logic       count_one;
		logic       full;
		logic       q_le_rd;
		logic       q_ge_rd;
		logic       bs_more;
		logic       hspec;
		logic       norm_done;
		logic       tol_lo;
		logic       tol_hi;
	} dp_status_t;

	// arctan(2^-i) in 2^-20 rad
	function automatic logic [19:0] atan_step(input logic [4:0] i);
		logic [19:0] v;
		unique case (i)
			5'd0:    v = 20'd823550;
			5'd1:    v = 20'd486170;
			5'd2:    v = 20'd256879;
			5'd3:    v = 20'd130396;
			5'd4:    v = 20'd65451;
			5'd5:    v = 20'd32757;
			5'd6:    v = 20'd16383;
			5'd7:    v = 20'd8192;
			5'd8:    v = 20'd4096;
			5'd9:    v = 20'd2048;
			5'd10:   v = 20'd1024;
			5'd11:   v = 20'd512;
			5'd12:   v = 20'd256;
			5'd13:   v = 20'd128;
			5'd14:   v = 20'd64;
			5'd15:   v = 20'd32;
			5'd16:   v = 20'd16;
			5'd17:   v = 20'd8;
			5'd18:   v = 20'd4;
			5'd19:   v = 20'd2;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/pali_dp.sv
// ----------------------------------------------------------------------------
// pali_dp: datapath of the path arc length interpolator
// Point store, square root, CORDIC heading, binary search and divider.
// ----------------------------------------------------------------------------
module pali_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pali_pkg::in_item_t   in_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  pali_pkg::dp_cmd_t    cmd,
	output pali_pkg::dp_status_t stat,
	output pali_pkg::out_item_t  res
);

	localparam int IW = pali_pkg::IDX_W;
	localparam int CW = pali_pkg::CNT_W;

	// point store
	logic signed [31:0] mem_x [pali_pkg::MAX_POINTS];
	logic signed [31:0] mem_y [pali_pkg::MAX_POINTS];
	logic [31:0]        mem_d [pali_pkg::MAX_POINTS];
	logic signed [15:0] mem_h [pali_pkg::MAX_POINTS];

	logic signed [31:0] rd_x_q, rd_y_q;
	logic [31:0]        rd_d_q;
	logic signed [15:0] rd_h_q;

	// control state
	logic [CW-1:0] count_q;
	logic [15:0]   tol_q;

	// request and result
	logic [1:0]         func_q;
	logic signed [31:0] px_q, py_q;
	logic [31:0]        qd_q;
	logic [1:0]         res_st_q;
	logic signed [31:0] res_x_q, res_y_q;
	logic [31:0]        res_d_q;
	logic signed [15:0] res_h_q;

	// append working registers
	logic [31:0]        ax_q, ay_q, pd_q;
	logic               dxneg_q, dyneg_q;
	logic [63:0]        sq_q, sv_q, sres_q, sbit_q;
	logic               ovf_q;
	logic signed [43:0] cx_q, cy_q, m_q;
	logic signed [22:0] z_q;

	// query working registers
	logic [IW-1:0]      lo_q, hi_q;
	logic signed [31:0] p1x_q, p1y_q, p2x_q, p2y_q;
	logic [31:0]        p1d_q, p2d_q;
	logic signed [15:0] p1h_q, p2h_q;
	logic [31:0]        lm_q, drem_q, dquo_q;
	logic               lneg_q;
	logic signed [33:0] lf1_q;

	// addresses
	logic [IW-1:0] last_idx, mid_idx, raddr, waddr;
	logic [IW:0]   lohi_sum;
	logic          we_new, we_prev;

	assign last_idx = count_q[IW-1:0] - IW'(1);
	assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_idx  = lohi_sum[IW:1];
	assign we_new   = (cmd.op == pali_pkg::DP_WRNEW);
	assign we_prev  = (cmd.op == pali_pkg::DP_WRPREV);
	assign waddr    = we_new ? count_q[IW-1:0] : last_idx;

	always_comb begin
		unique case (cmd.rsel)
			pali_pkg::RS_ZERO: raddr = '0;
			pali_pkg::RS_LAST: raddr = last_idx;
			pali_pkg::RS_MID:  raddr = mid_idx;
			pali_pkg::RS_LO:   raddr = lo_q;
			pali_pkg::RS_HI:   raddr = hi_q;
			default:           raddr = '0;
		endcase
	end

	// store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we_new) begin
			mem_x[waddr] <= px_q;
			mem_y[waddr] <= py_q;
			mem_d[waddr] <= res_d_q;
			mem_h[waddr] <= res_h_q;
		end else if (we_prev) begin
			mem_h[waddr] <= res_h_q;
		end
		rd_x_q <= mem_x[raddr];
		rd_y_q <= mem_y[raddr];
		rd_d_q <= mem_d[raddr];
		rd_h_q <= mem_h[raddr];
	end

	// --- append arithmetic ---
	logic signed [32:0] dx, dy;
	logic [64:0]        sq_sum;
	logic [63:0]        sqrt_trial;
	logic [31:0]        step;
	logic [32:0]        cum;
	logic [31:0]        cum_sat;
	logic signed [43:0] xs, ys;
	logic [20:0]        zc;
	logic [21:0]        zr;
	logic [14:0]        ang;
	logic signed [15:0] hq1, hq;

	assign dx         = 33'(px_q) - 33'(rd_x_q);
	assign dy         = 33'(py_q) - 33'(rd_y_q);
	assign sq_sum     = {1'b0, sq_q} + 65'(ay_q * ay_q);
	assign sqrt_trial = sres_q + sbit_q;
	assign step       = ovf_q ? 32'hFFFF_FFFF : sres_q[31:0];
	assign cum        = {1'b0, pd_q} + {1'b0, step};
	assign cum_sat    = cum[32] ? 32'hFFFF_FFFF : cum[31:0];
	assign xs         = cx_q >>> cmd.idx;
	assign ys         = cy_q >>> cmd.idx;

	// clamp the CORDIC angle to a quarter turn, round to Q2.13, map quadrant
	always_comb begin
		if (z_q < 0)
			zc = '0;
		else if (z_q > 23'(pali_pkg::HALF_PI_Z))
			zc = pali_pkg::HALF_PI_Z;
		else
			zc = z_q[20:0];
		zr = {1'b0, zc} + 22'd64;
		if (ay_q == '0)
			ang = '0;
		else if (ax_q == '0)
			ang = pali_pkg::HALF_PI_Q13;
		else
			ang = zr[21:7];
		hq1 = dxneg_q ? (pali_pkg::PI_Q13 - 16'(ang)) : 16'(ang);
		hq  = dyneg_q ? -hq1 : hq1;
	end

	// --- query arithmetic ---
	logic [31:0]        num, den, hi_gap;
	logic signed [33:0] f1, f2, h2raw, dh, fd, lres;
	logic [33:0]        fmag;
	logic [63:0]        prod, dividend;
	logic [32:0]        dtrial;
	logic               dbit;

	assign num    = qd_q - p1d_q;
	assign den    = p2d_q - p1d_q;
	assign hi_gap = p2d_q - qd_q;

	// pick the ends of the field being interpolated; heading unwraps by 2*pi
	always_comb begin
		h2raw = 34'(p2h_q);
		dh    = h2raw - 34'(p1h_q);
		unique case (cmd.field)
			pali_pkg::LF_X: begin
				f1 = 34'(p1x_q);
				f2 = 34'(p2x_q);
			end
			pali_pkg::LF_Y: begin
				f1 = 34'(p1y_q);
				f2 = 34'(p2y_q);
			end
			default: begin
				f1 = 34'(p1h_q);
				if (dh > pali_pkg::PI_W)
					f2 = h2raw - pali_pkg::TWO_PI_W;
				else if (dh < -pali_pkg::PI_W)
					f2 = h2raw + pali_pkg::TWO_PI_W;
				else
					f2 = h2raw;
			end
		endcase
		fd   = f2 - f1;
		fmag = fd[33] ? 34'(-fd) : 34'(fd);
	end

	assign prod     = lm_q * num;
	assign dividend = prod + 64'(den[31:1]);
	assign dtrial   = {drem_q, dquo_q[31]};
	assign dbit     = (dtrial >= {1'b0, den});
	assign lres     = lneg_q ? (lf1_q - 34'(dquo_q)) : (lf1_q + 34'(dquo_q));

	// status to the controller
	always_comb begin
		stat.func       = func_q;
		stat.count_zero = (count_q == '0);
		stat.count_one  = (count_q == CW'(1));
		stat.full       = (count_q >= pali_pkg::FULL_COUNT);
		stat.q_le_rd    = (qd_q <= rd_d_q);
		stat.q_ge_rd    = (qd_q >= rd_d_q);
		stat.bs_more    = ({1'b0, lo_q} + (IW+1)'(1)) < {1'b0, hi_q};
		stat.hspec      = (ax_q == '0) || (ay_q == '0);
		stat.norm_done  = (m_q[43:40] != '0);
		stat.tol_lo     = (den < 32'(tol_q)) || (num < 32'(tol_q));
		stat.tol_hi     = (hi_gap < 32'(tol_q));
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tol_q   <= 16'd66;
		end else begin
			if (cfg_we)
				tol_q <= cfg_wdata;
			if (cmd.op == pali_pkg::DP_CLEAR)
				count_q <= '0;
			else if (we_new)
				count_q <= count_q + CW'(1);
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			pali_pkg::DP_LOAD: begin
				func_q   <= in_data.func;
				px_q     <= in_data.point_x;
				py_q     <= in_data.point_y;
				qd_q     <= in_data.query_distance;
				res_st_q <= pali_pkg::ST_OK;
				res_x_q  <= '0;
				res_y_q  <= '0;
				res_d_q  <= '0;
				res_h_q  <= '0;
			end
			pali_pkg::DP_FULL:  res_st_q <= pali_pkg::ST_FULL;
			pali_pkg::DP_EMPTY: res_st_q <= pali_pkg::ST_EMPTY;
			pali_pkg::DP_DIFF: begin
				ax_q    <= dx[32] ? 32'(-dx) : dx[31:0];
				ay_q    <= dy[32] ? 32'(-dy) : dy[31:0];
				dxneg_q <= dx[32];
				dyneg_q <= dy[32];
				pd_q    <= rd_d_q;
			end
			pali_pkg::DP_SQX: sq_q <= ax_q * ax_q;
			pali_pkg::DP_SQY: begin
				ovf_q  <= sq_sum[64];
				sv_q   <= sq_sum[63:0];
				sres_q <= '0;
				sbit_q <= 64'd1 << 62;
			end
			// one result bit per step
			pali_pkg::DP_SQRT: begin
				if (sv_q >= sqrt_trial) begin
					sv_q   <= sv_q - sqrt_trial;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			pali_pkg::DP_NINIT: begin
				cx_q <= 44'(ax_q);
				cy_q <= 44'(ay_q);
				m_q  <= (ax_q > ay_q) ? 44'(ax_q) : 44'(ay_q);
				z_q  <= '0;
			end
			// normalise: bytes while far below the target, then bits
			pali_pkg::DP_NSTEP: begin
				if (m_q[43:32] == '0) begin
					cx_q <= cx_q <<< 8;
					cy_q <= cy_q <<< 8;
					m_q  <= m_q <<< 8;
				end else begin
					cx_q <= cx_q <<< 1;
					cy_q <= cy_q <<< 1;
					m_q  <= m_q <<< 1;
				end
			end
			// one vectoring rotation
			pali_pkg::DP_CORDIC: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					z_q  <= z_q + 23'(pali_pkg::atan_step(cmd.idx));
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					z_q  <= z_q - 23'(pali_pkg::atan_step(cmd.idx));
				end
			end
			pali_pkg::DP_HFIN: begin
				res_d_q <= cum_sat;
				res_h_q <= hq;
			end
			pali_pkg::DP_EMIT_RD: begin
				res_x_q <= rd_x_q;
				res_y_q <= rd_y_q;
				res_d_q <= rd_d_q;
				res_h_q <= rd_h_q;
			end
			pali_pkg::DP_EMIT_P1: begin
				res_x_q <= p1x_q;
				res_y_q <= p1y_q;
				res_d_q <= p1d_q;
				res_h_q <= p1h_q;
			end
			pali_pkg::DP_EMIT_P2: begin
				res_x_q <= p2x_q;
				res_y_q <= p2y_q;
				res_d_q <= p2d_q;
				res_h_q <= p2h_q;
			end
			pali_pkg::DP_BSINIT: begin
				lo_q <= '0;
				hi_q <= last_idx;
			end
			pali_pkg::DP_BSUPD: begin
				if (!stat.q_le_rd)
					lo_q <= mid_idx;
				else
					hi_q <= mid_idx;
			end
			pali_pkg::DP_CAP1: begin
				p1x_q <= rd_x_q;
				p1y_q <= rd_y_q;
				p1d_q <= rd_d_q;
				p1h_q <= rd_h_q;
			end
			pali_pkg::DP_CAP2: begin
				p2x_q <= rd_x_q;
				p2y_q <= rd_y_q;
				p2d_q <= rd_d_q;
				p2h_q <= rd_h_q;
			end
			pali_pkg::DP_LDIFF: begin
				lm_q   <= fmag[31:0];
				lneg_q <= fd[33];
				lf1_q  <= f1;
			end
			// high half is below den, so 32 steps give the quotient
			pali_pkg::DP_LMUL: begin
				drem_q <= dividend[63:32];
				dquo_q <= dividend[31:0];
			end
			pali_pkg::DP_DIV: begin
				drem_q <= dbit ? 32'(dtrial - {1'b0, den}) : dtrial[31:0];
				dquo_q <= {dquo_q[30:0], dbit};
			end
			pali_pkg::DP_LFIN: begin
				res_d_q <= qd_q;
				unique case (cmd.field)
					pali_pkg::LF_X: res_x_q <= lres[31:0];
					pali_pkg::LF_Y: res_y_q <= lres[31:0];
					default:        res_h_q <= lres[15:0];
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		res.status       = res_st_q;
		res.out_x        = res_x_q;
		res.out_y        = res_y_q;
		res.out_distance = res_d_q;
		res.out_heading  = res_h_q;
		res.point_count  = count_q;
	end

endmodule

FILE: rtl/pali_ctrl.sv
// ----------------------------------------------------------------------------
// pali_ctrl: sequencer of the path arc length interpolator
// Steps the datapath through clear, append and query, one request at a time.
// ----------------------------------------------------------------------------
module pali_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_free,
	output logic                 push,
	input  pali_pkg::dp_status_t stat,
	output pali_pkg::dp_cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_ADIFF,
		S_SQX,
		S_SQY,
		S_SQRT,
		S_HSEL,
		S_NORM,
		S_CORD,
		S_HFIN,
		S_WRPREV,
		S_WRNEW,
		S_QCHK0,
		S_QCHKL,
		S_BS,
		S_BSCMP,
		S_RLO,
		S_RHI,
		S_TOL,
		S_LDIFF,
		S_LMUL,
		S_DIV,
		S_LFIN,
		S_FIN
	} state_t;

	state_t                state_q, state_d;
	logic [4:0]            cnt_q, cnt_d;
	pali_pkg::lfield_t     field_q, field_d;

	assign in_ready = (state_q == S_IDLE);
	assign push     = (state_q == S_FIN) && out_free;

	// next state and datapath command
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		field_d   = field_q;
		cmd.op    = pali_pkg::DP_NOP;
		cmd.rsel  = pali_pkg::RS_ZERO;
		cmd.idx   = cnt_q;
		cmd.field = field_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = pali_pkg::DP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (stat.func == pali_pkg::FUNC_CLEAR) begin
					cmd.op  = pali_pkg::DP_CLEAR;
					state_d = S_FIN;
				end else if (stat.func == pali_pkg::FUNC_APPEND) begin
					if (stat.full) begin
						cmd.op  = pali_pkg::DP_FULL;
						state_d = S_FIN;
					end else if (stat.count_zero) begin
						state_d = S_WRNEW;
					end else begin
						cmd.rsel = pali_pkg::RS_LAST;
						state_d  = S_ADIFF;
					end
				end else if (stat.func == pali_pkg::FUNC_QUERY) begin
					if (stat.count_zero) begin
						cmd.op  = pali_pkg::DP_EMPTY;
						state_d = S_FIN;
					end else begin
						cmd.rsel = pali_pkg::RS_ZERO;
						state_d  = S_QCHK0;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			// append: step length
			S_ADIFF: begin
				cmd.op  = pali_pkg::DP_DIFF;
				state_d = S_SQX;
			end
			S_SQX: begin
				cmd.op  = pali_pkg::DP_SQX;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.op  = pali_pkg::DP_SQY;
				cnt_d   = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = pali_pkg::DP_SQRT;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					state_d = S_HSEL;
			end
			// append: heading
			S_HSEL: begin
				if (stat.hspec) begin
					state_d = S_HFIN;
				end else begin
					cmd.op  = pali_pkg::DP_NINIT;
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				if (stat.norm_done) begin
					cnt_d   = '0;
					state_d = S_CORD;
				end else begin
					cmd.op = pali_pkg::DP_NSTEP;
				end
			end
			S_CORD: begin
				cmd.op = pali_pkg::DP_CORDIC;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == 5'(pali_pkg::CORDIC_STEPS - 1))
					state_d = S_HFIN;
			end
			S_HFIN: begin
				cmd.op  = pali_pkg::DP_HFIN;
				state_d = S_WRPREV;
			end
			S_WRPREV: begin
				cmd.op  = pali_pkg::DP_WRPREV;
				state_d = S_WRNEW;
			end
			S_WRNEW: begin
				cmd.op  = pali_pkg::DP_WRNEW;
				state_d = S_FIN;
			end
			// query: clamp to the ends
			S_QCHK0: begin
				if (stat.count_one || stat.q_le_rd) begin
					cmd.op  = pali_pkg::DP_EMIT_RD;
					state_d = S_FIN;
				end else begin
					cmd.rsel = pali_pkg::RS_LAST;
					state_d  = S_QCHKL;
				end
			end
			S_QCHKL: begin
				if (stat.q_ge_rd) begin
					cmd.op  = pali_pkg::DP_EMIT_RD;
					state_d = S_FIN;
				end else begin
					cmd.op  = pali_pkg::DP_BSINIT;
					state_d = S_BS;
				end
			end
			// query: binary search, each probe a read in S_BS and a compare in S_BSCMP
			S_BS: begin
				if (stat.bs_more) begin
					cmd.rsel = pali_pkg::RS_MID;
					state_d  = S_BSCMP;
				end else begin
					cmd.rsel = pali_pkg::RS_LO;
					state_d  = S_RLO;
				end
			end
			S_BSCMP: begin
				cmd.rsel = pali_pkg::RS_MID;
				cmd.op   = pali_pkg::DP_BSUPD;
				state_d  = S_BS;
			end
			S_RLO: begin
				cmd.op   = pali_pkg::DP_CAP1;
				cmd.rsel = pali_pkg::RS_HI;
				state_d  = S_RHI;
			end
			S_RHI: begin
				cmd.op  = pali_pkg::DP_CAP2;
				state_d = S_TOL;
			end
			S_TOL: begin
				priority if (stat.tol_lo) begin
					cmd.op  = pali_pkg::DP_EMIT_P1;
					state_d = S_FIN;
				end else if (stat.tol_hi) begin
					cmd.op  = pali_pkg::DP_EMIT_P2;
					state_d = S_FIN;
				end else begin
					field_d = pali_pkg::LF_X;
					state_d = S_LDIFF;
				end
			end
			// query: interpolate x, y, heading in turn
			S_LDIFF: begin
				cmd.op  = pali_pkg::DP_LDIFF;
				state_d = S_LMUL;
			end
			S_LMUL: begin
				cmd.op  = pali_pkg::DP_LMUL;
				cnt_d   = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = pali_pkg::DP_DIV;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					state_d = S_LFIN;
			end
			S_LFIN: begin
				cmd.op = pali_pkg::DP_LFIN;
				unique case (field_q)
					pali_pkg::LF_X: begin
						field_d = pali_pkg::LF_Y;
						state_d = S_LDIFF;
					end
					pali_pkg::LF_Y: begin
						field_d = pali_pkg::LF_H;
						state_d = S_LDIFF;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_FIN: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			field_q <= pali_pkg::LF_X;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			field_q <= field_d;
		end
	end

endmodule

FILE: rtl/path_arc_length_interpolator_top.sv
// ----------------------------------------------------------------------------
// path_arc_length_interpolator_top: polyline store with arc-length look-up
// Appends points with running distance and heading; answers distance queries.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one request (clear, append, query);
// output channel out_valid/out_ready returns exactly one result per request.
// cfg_we/cfg_wdata writes the distance tolerance; write it only while idle.
// One request is worked on at a time:
//   clear: sets the point count to zero.
//   append: the 32-step square root, 2 to 12 normalising shifts and the
//     20 CORDIC rotations; shifts and rotations are skipped when the step
//     lies on an axis (no rotations); the first point skips all of them.
//   query: no search when clamped to an end; otherwise binary-search probes
//     (up to 10 probes over 1024 points, the store has one registered read
//     port), then, unless the query lies within the tolerance of a point, the
//     32-step divider for each interpolated field (x, y, heading).
// Results go to an output register, so the next request is taken while a
// result still waits; a stalled receiver holds the block only once a second
// result is ready. Reset empties the store (count to zero, contents are
// left as they are) and sets the tolerance to 66; no clearing pass.
// ----------------------------------------------------------------------------
module path_arc_length_interpolator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pali_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pali_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata
);

	pali_pkg::dp_cmd_t    cmd;
	pali_pkg::dp_status_t stat;
	pali_pkg::out_item_t  res;
	pali_pkg::out_item_t  out_q;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 push;

	assign out_free = !out_valid_q || out_ready;

	pali_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.push     (push),
		.stat     (stat),
		.cmd      (cmd)
	);

	pali_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: arc-length interpolator check
// A table of directed requests, then random path building and distance
// look-ups under several tolerances. Results are compared field by field,
// typed rows against the table, others against a behavioural model kept here.
// ----------------------------------------------------------------------------
module testbench;

	localparam int IDLE_PCT   = 12;
	localparam int STALL_LIM  = 4000;
	localparam int DRAIN_WAIT = 300;
	localparam longint PI_H   = 25736;
	localparam longint TWO_PI = 51472;
	localparam longint HALF_Z = 1647099;
	localparam longint ATAN_Z [20] = '{823550, 486170, 256879, 130396, 65451, 32757,
		16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
	// function code with no operation behind it
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	typedef struct {
		pali_pkg::in_item_t  req;
		bit                  typed;
		pali_pkg::out_item_t res;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	pali_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	pali_pkg::out_item_t out_data;
	logic                cfg_we = 1'b0;
	logic [15:0]         cfg_wdata = '0;

	// model of the path store
	logic signed [31:0] path_x [pali_pkg::MAX_POINTS];
	logic signed [31:0] path_y [pali_pkg::MAX_POINTS];
	logic [31:0]        path_dist [pali_pkg::MAX_POINTS];
	logic signed [15:0] path_hdg [pali_pkg::MAX_POINTS];
	int                 path_len = 0;
	logic [15:0]        tol = 16'd66;

	pali_pkg::out_item_t result_q [$];
	row_t                rows [$];
	int                  errors = 0;
	int                  quiet_cycles = 0;
	bit                  no_idle = 1'b0;

	path_arc_length_interpolator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// integer square root, floor
	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] res, bits;
		res = 0;
		bits = 64'd1 << 62;
		while (bits > v)
			bits >>= 2;
		while (bits != 0) begin
			if (v >= res + bits) begin
				v = v - (res + bits);
				res = (res >> 1) + bits;
			end else begin
				res = res >> 1;
			end
			bits >>= 2;
		end
		return res;
	endfunction

	// step heading by CORDIC vectoring, mapped to its quadrant
	function automatic longint step_heading(input longint dx, input longint dy);
		logic [63:0] ax, ay, m;
		longint cx, cy, cz, xs, ys, a;
		int sh;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		if (ay == 0) begin
			a = 0;
		end else if (ax == 0) begin
			a = (HALF_Z + 64) >>> 7;
		end else begin
			m = ax > ay ? ax : ay;
			sh = 0;
			while ((m << sh) < (64'd1 << 40))
				sh++;
			cx = longint'(ax << sh);
			cy = longint'(ay << sh);
			cz = 0;
			for (int i = 0; i < 20; i++) begin
				xs = cx >>> i;
				ys = cy >>> i;
				if (cy > 0) begin
					cx += ys; cy -= xs; cz += ATAN_Z[i];
				end else begin
					cx -= ys; cy += xs; cz -= ATAN_Z[i];
				end
			end
			if (cz < 0) cz = 0;
			if (cz > HALF_Z) cz = HALF_Z;
			a = (cz + 64) >>> 7;
		end
		if (dx < 0) a = PI_H - a;
		if (dy < 0) a = -a;
		return a;
	endfunction

	// linear blend, magnitude of the quotient rounded half away from zero
	function automatic longint blend(input longint f1, input longint f2,
			input logic [63:0] num, input logic [63:0] den);
		longint d;
		logic [63:0] m, q;
		d = f2 - f1;
		m = d < 0 ? -d : d;
		q = (m * num + den / 2) / den;
		return d < 0 ? f1 - longint'(q) : f1 + longint'(q);
	endfunction

	function automatic pali_pkg::out_item_t point_at(input int i);
		pali_pkg::out_item_t o;
		o = '0;
		o.out_x = path_x[i];
		o.out_y = path_y[i];
		o.out_distance = path_dist[i];
		o.out_heading = path_hdg[i];
		return o;
	endfunction

	// work out the result of one request and advance the model
	function automatic pali_pkg::out_item_t predict_result(input pali_pkg::in_item_t r);
		pali_pkg::out_item_t o;
		longint dx, dy, h1, h2;
		logic [63:0] ax, ay, sq, t, stp, cum;
		logic [31:0] s, q, s1, s2;
		logic signed [15:0] h;
		int n, lo, hi, mid;
		o = '0;
		n = path_len;
		case (r.func)
			pali_pkg::FUNC_CLEAR: path_len = 0;
			pali_pkg::FUNC_APPEND: begin
				if (n >= pali_pkg::MAX_POINTS) begin
					o.status = pali_pkg::ST_FULL;
				end else begin
					s = 0;
					h = 0;
					if (n > 0) begin
						dx = longint'(r.point_x) - longint'(path_x[n-1]);
						dy = longint'(r.point_y) - longint'(path_y[n-1]);
						ax = dx < 0 ? -dx : dx;
						ay = dy < 0 ? -dy : dy;
						sq = ax * ax;
						t = sq + ay * ay;
						stp = (t < sq) ? 64'hFFFF_FFFF : root_floor(t);
						cum = path_dist[n-1] + stp;
						s = cum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : cum[31:0];
						h = 16'(step_heading(dx, dy));
						path_hdg[n-1] = h;
					end
					path_x[n] = r.point_x;
					path_y[n] = r.point_y;
					path_dist[n] = s;
					path_hdg[n] = h;
					path_len = n + 1;
					o.out_distance = s;
					o.out_heading = h;
				end
			end
			pali_pkg::FUNC_QUERY: begin
				q = r.query_distance;
				if (n == 0) begin
					o.status = pali_pkg::ST_EMPTY;
				end else if (n == 1 || q <= path_dist[0]) begin
					o = point_at(0);
				end else if (q >= path_dist[n-1]) begin
					o = point_at(n - 1);
				end else begin
					lo = 0;
					hi = n - 1;
					while (lo + 1 < hi) begin
						mid = (lo + hi) / 2;
						if (q > path_dist[mid]) lo = mid; else hi = mid;
					end
					s1 = path_dist[lo];
					s2 = path_dist[hi];
					if (s2 - s1 < tol || q - s1 < tol) begin
						o = point_at(lo);
					end else if (s2 - q < tol) begin
						o = point_at(hi);
					end else begin
						h1 = path_hdg[lo];
						h2 = path_hdg[hi];
						if (h2 - h1 > PI_H) h2 -= TWO_PI;
						else if (h2 - h1 < -PI_H) h2 += TWO_PI;
						o.out_x = 32'(blend(path_x[lo], path_x[hi], q - s1, s2 - s1));
						o.out_y = 32'(blend(path_y[lo], path_y[hi], q - s1, s2 - s1));
						o.out_distance = q;
						o.out_heading = 16'(blend(h1, h2, q - s1, s2 - s1));
					end
				end
			end
			default: ;
		endcase
		o.point_count = pali_pkg::CNT_W'(path_len);
		return o;
	endfunction

	task automatic report(input string what);
		$display("mismatch %s at %0t", what, $realtime);
		errors++;
	endtask

	// drive one request; queue its expected result on acceptance
	task automatic send_request(input pali_pkg::in_item_t r, input bit typed,
			input pali_pkg::out_item_t res);
		pali_pkg::out_item_t p;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		p = predict_result(r);
		if (typed)
			p = res;
		result_q = {result_q, p};
	endtask

	// tolerance change: only once every result is back
	task automatic write_tolerance(input logic [15:0] v);
		in_valid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol = v;
	endtask

	function automatic void add_row(input logic [1:0] f, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] qd, input bit typed,
			input pali_pkg::out_item_t res);
		row_t w;
		w.req = '{f, px, py, qd};
		w.typed = typed;
		w.res = res;
		rows = {rows, w};
	endfunction

	// random request shaped by the model's current path
	function automatic pali_pkg::in_item_t random_request(input bit grow_only);
		pali_pkg::in_item_t r;
		int k, i, n;
		logic [63:0] last;
		r.point_x = $urandom;
		r.point_y = $urandom;
		r.query_distance = $urandom;
		n = path_len;
		k = grow_only ? 10 : $urandom_range(99);
		if (k < 2) begin
			r.func = pali_pkg::FUNC_CLEAR;
		end else if (k < 5) begin
			r.func = FUNC_SPARE;
		end else if (k < 55) begin
			r.func = pali_pkg::FUNC_APPEND;
			k = $urandom_range(99);
			if (n > 0 && k < 85) begin
				r.point_x = path_x[n-1] + 32'($urandom_range(32'h40000) - 32'h20000);
				r.point_y = path_y[n-1] + 32'($urandom_range(32'h40000) - 32'h20000);
			end else if (n > 0 && k < 95) begin
				r.point_x = path_x[n-1] + 32'($urandom_range(8) - 4);
				r.point_y = path_y[n-1];
			end
		end else begin
			r.func = pali_pkg::FUNC_QUERY;
			k = $urandom_range(99);
			last = n > 0 ? path_dist[n-1] : 0;
			if (n > 1 && k < 40) begin
				i = $urandom_range(n - 2);
				r.query_distance = path_dist[i] +
					32'(($urandom % (64'(path_dist[i+1]) - path_dist[i] + 1)));
			end else if (n > 0 && k < 60) begin
				i = $urandom_range(n - 1);
				r.query_distance = path_dist[i] + 32'($urandom_range(2 * tol + 4)) - tol - 2;
			end else if (k < 70) begin
				r.query_distance = $urandom_range(1) ? 32'(last) : 32'd0;
			end else if (k < 90) begin
				r.query_distance = 32'($urandom % (last + 1));
			end
		end
		return r;
	endfunction

	// result checker and receiver stalls
	always @(posedge clk) begin
		pali_pkg::out_item_t want;
		if (out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				report($sformatf("unexpected result %0h", out_data));
			end else begin
				want = result_q.pop_front();
				if (out_data.status !== want.status)
					report($sformatf("status: got %0h, expected %0h",
						out_data.status, want.status));
				if (out_data.out_x !== want.out_x)
					report($sformatf("out_x: got %0h, expected %0h",
						out_data.out_x, want.out_x));
				if (out_data.out_y !== want.out_y)
					report($sformatf("out_y: got %0h, expected %0h",
						out_data.out_y, want.out_y));
				if (out_data.out_distance !== want.out_distance)
					report($sformatf("out_distance: got %0h, expected %0h",
						out_data.out_distance, want.out_distance));
				if (out_data.out_heading !== want.out_heading)
					report($sformatf("out_heading: got %0h, expected %0h",
						out_data.out_heading, want.out_heading));
				if (out_data.point_count !== want.point_count)
					report($sformatf("point_count: got %0h, expected %0h",
						out_data.point_count, want.point_count));
			end
		end
		out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIM) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		pali_pkg::out_item_t nil;
		nil = '0;
		// directed table; typed results where obvious
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 32'h1234, 1,
			'{pali_pkg::ST_EMPTY, 0, 0, 0, 0, 0});
		add_row(FUNC_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, nil);
		add_row(pali_pkg::FUNC_APPEND, 0, 0, 0, 1, '{pali_pkg::ST_OK, 0, 0, 0, 0, 1});
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 0, 1, '{pali_pkg::ST_OK, 0, 0, 0, 0, 1});
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 32'hFFFF_FFFF, 1,
			'{pali_pkg::ST_OK, 0, 0, 0, 0, 1});
		add_row(pali_pkg::FUNC_APPEND, 32'h10000, 0, 0, 1,
			'{pali_pkg::ST_OK, 0, 0, 32'h10000, 0, 2});
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 32'h8000, 1,
			'{pali_pkg::ST_OK, 32'h8000, 0, 32'h8000, 0, 2});
		add_row(pali_pkg::FUNC_APPEND, 32'h10000, 32'h10000, 0, 1,
			'{pali_pkg::ST_OK, 0, 0, 32'h20000, 16'sd12868, 3});
		add_row(pali_pkg::FUNC_APPEND, 0, 32'h10000, 0, 1,
			'{pali_pkg::ST_OK, 0, 0, 32'h30000, pali_pkg::PI_Q13, 4});
		add_row(pali_pkg::FUNC_APPEND, 0, 0, 0, 1,
			'{pali_pkg::ST_OK, 0, 0, 32'h40000, -16'sd12868, 5});
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 32'h40000, 1,
			'{pali_pkg::ST_OK, 0, 0, 32'h40000, -16'sd12868, 5});
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 32'h18000, 0, nil);
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 32'h2C000, 0, nil);
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 32'h38000, 0, nil);
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 32'h10000 + 30, 0, nil);
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 32'h20000 - 30, 0, nil);
		add_row(pali_pkg::FUNC_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, nil);
		add_row(pali_pkg::FUNC_APPEND, 32'h8000_0000, 32'h8000_0000, 0, 0, nil);
		add_row(pali_pkg::FUNC_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, nil);
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 32'hFFFF_FFF0, 0, nil);
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 32'h7FFF_0000, 0, nil);
		add_row(pali_pkg::FUNC_CLEAR, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_AAAA, 1, nil);
		add_row(pali_pkg::FUNC_QUERY, 0, 0, 0, 1, '{pali_pkg::ST_EMPTY, 0, 0, 0, 0, 0});
		add_row(pali_pkg::FUNC_APPEND, -32'sd5, 32'sd7, 0, 1,
			'{pali_pkg::ST_OK, 0, 0, 0, 0, 1});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_request(rows[i].req, rows[i].typed, rows[i].res);

		// tolerance zero, with a stretch of no idling on either side
		write_tolerance(16'd0);
		for (int i = 0; i < 120; i++) begin
			no_idle = (i >= 20 && i < 100);
			send_request(random_request(0), 0, nil);
		end
		no_idle = 1'b0;

		// widest tolerance
		write_tolerance(16'hFFFF);
		for (int i = 0; i < 120; i++)
			send_request(random_request(0), 0, nil);

		// random tolerance; grow a fresh path, then mixed requests on it
		write_tolerance(16'($urandom_range(16'hFFFF)));
		send_request('{pali_pkg::FUNC_CLEAR, 32'd0, 32'd0, 32'd0}, 0, nil);
		for (int i = 0; i < 60; i++)
			send_request(random_request(1), 0, nil);
		for (int i = 0; i < 75; i++)
			send_request(random_request(0), 0, nil);
		in_valid <= 1'b0;

		while (result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
